>>> rtl/core/gppc_pkg.sv
// gppc_pkg: shared types, codes and port mapping functions of the gpio pseudo port controller
package gppc_pkg;

   localparam int unsigned NUM_PHYS   = 4;
   localparam int unsigned WORD_W     = 32;
   localparam int unsigned KIND_W     = 4;
   localparam int unsigned PORT_W     = 3;

   typedef logic [WORD_W-1:0]         word_type;
   typedef word_type [NUM_PHYS-1:0]   bank_type;
   typedef logic [KIND_W-1:0]         kind_code_type;
   typedef logic [PORT_W-1:0]         port_code_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_SETVAL  = 4'd0,
      KIND_PINSET  = 4'd1,
      KIND_PINCLR  = 4'd2,
      KIND_PORTIN  = 4'd3,
      KIND_PININ   = 4'd4,
      KIND_PORTOUT = 4'd5,
      KIND_PINOUT  = 4'd6,
      KIND_GETVAL  = 4'd7,
      KIND_PINGET  = 4'd8,
      KIND_PULLUP  = 4'd9,
      KIND_NOPULL  = 4'd10
   } kind_type;

   typedef enum logic [PORT_W-1:0] {
      PORT_A = 3'd0,
      PORT_B = 3'd1,
      PORT_C = 3'd2,
      PORT_D = 3'd3,
      PORT_E = 3'd4
   } port_type;

   localparam word_type MASK_A       = 32'h7FFF_FFFF;
   localparam word_type MASK_LOW6    = 32'h0000_003F;
   localparam word_type MASK_HIGH26  = 32'hFFFF_FFC0;
   localparam word_type MASK_E_PHYS  = 32'h0000_3FC0;
   localparam word_type MASK_ALL     = 32'hFFFF_FFFF;
   localparam word_type MASK_E_LOG   = 32'h0000_00FF;
   localparam word_type READ_IN_SENTINEL = 32'h0000_0000;
   localparam word_type RESULT_WRITE = 32'h0000_0001;
   localparam word_type RESULT_NONE  = 32'h0000_0000;

   // one request as held in the input stage
   typedef struct packed {
      kind_code_type kind;
      port_code_type port;
      word_type      mask;
      bank_type      pins;
   } req_item_type;

   // register bank contents and their update strobe
   typedef struct packed {
      bank_type ov;
      bank_type ge;
      bank_type oe;
      bank_type pu;
   } banks_type;

   typedef struct packed {
      logic      we;
      banks_type nxt;
   } bank_upd_type;

   function automatic word_type lport_read(port_code_type p, bank_type r);
      word_type v;
      v = '0;
      unique case (p)
         PORT_A:  v = r[0] & MASK_A;
         PORT_B:  v = r[1];
         PORT_C:  v = r[2] & MASK_LOW6;
         PORT_D:  v = ((r[2] & MASK_HIGH26) >> 6) | ((r[3] & MASK_LOW6) << 26);
         PORT_E:  v = (r[3] & MASK_E_PHYS) >> 6;
         default: v = '0;
      endcase
      return v;
   endfunction

   function automatic bank_type lport_write(port_code_type p, bank_type r, word_type v);
      bank_type w;
      w = r;
      unique case (p)
         PORT_A: w[0] = v & MASK_A;
         PORT_B: w[1] = v;
         PORT_C: w[2] = (r[2] & ~MASK_LOW6) | (v & MASK_LOW6);
         PORT_D: begin
            w[2] = (r[2] & MASK_LOW6) | (v << 6);
            w[3] = (r[3] & ~MASK_LOW6) | (v >> 26);
         end
         PORT_E:  w[3] = (r[3] & ~MASK_E_PHYS) | ((v & MASK_E_LOG) << 6);
         default: w = r;
      endcase
      return w;
   endfunction

endpackage

>>> rtl/core/gppc_chan_if.sv
// gppc_chan_if: request and response channel interfaces
interface gppc_req_if;
   logic                        valid;
   logic                        ready;
   gppc_pkg::kind_code_type     kind;
   gppc_pkg::port_code_type     port;
   gppc_pkg::word_type          mask;
   gppc_pkg::word_type          pins_port0;
   gppc_pkg::word_type          pins_port1;
   gppc_pkg::word_type          pins_port2;
   gppc_pkg::word_type          pins_port3;

   modport source (output valid, kind, port, mask, pins_port0, pins_port1, pins_port2,
                   pins_port3, input ready);
   modport sink   (input valid, kind, port, mask, pins_port0, pins_port1, pins_port2,
                   pins_port3, output ready);
endinterface

interface gppc_rsp_if;
   logic               valid;
   logic               ready;
   gppc_pkg::word_type result;

   modport source (output valid, result, input ready);
   modport sink   (input valid, result, output ready);
endinterface

>>> rtl/core/gppc_in_reg.sv
// gppc_in_reg: input register stage holding one request
module gppc_in_reg (
   input  logic                   clock,
   input  logic                   reset,
   gppc_req_if.sink               req_chan,
   input  logic                   advance,
   output logic                   item_valid,
   output gppc_pkg::req_item_type item
);

   logic                   valid_ff, valid_in;
   gppc_pkg::req_item_type item_ff, item_in;
   logic                   take;

   // accept while empty or while the held request moves on
   assign take           = !valid_ff || advance;
   assign req_chan.ready = take;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (take) begin
         valid_in = req_chan.valid;
         item_in  = '{kind: req_chan.kind, port: req_chan.port, mask: req_chan.mask,
                      pins: {req_chan.pins_port3, req_chan.pins_port2,
                             req_chan.pins_port1, req_chan.pins_port0}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

>>> rtl/core/gppc_exec.sv
// gppc_exec: decodes one request, forms the bank updates and the result
module gppc_exec (
   input  logic                   item_valid,
   input  logic                   advance,
   input  gppc_pkg::req_item_type item,
   input  gppc_pkg::banks_type    banks,
   output gppc_pkg::bank_upd_type upd,
   output gppc_pkg::word_type     result
);

   gppc_pkg::word_type  m_eff;
   gppc_pkg::banks_type nxt;
   gppc_pkg::word_type  res;

   always_comb begin
      nxt   = banks;
      res   = gppc_pkg::RESULT_WRITE;
      m_eff = item.mask;
      if (item.kind == gppc_pkg::KIND_PORTIN || item.kind == gppc_pkg::KIND_PORTOUT) begin
         m_eff = gppc_pkg::MASK_ALL;
      end
      unique case (item.kind) inside
         gppc_pkg::KIND_SETVAL: begin
            nxt.ov = gppc_pkg::lport_write(item.port, banks.ov, item.mask);
         end
         gppc_pkg::KIND_PINSET: begin
            nxt.ov = gppc_pkg::lport_write(item.port, banks.ov,
                        gppc_pkg::lport_read(item.port, banks.ov) | item.mask);
         end
         gppc_pkg::KIND_PINCLR: begin
            nxt.ov = gppc_pkg::lport_write(item.port, banks.ov,
                        gppc_pkg::lport_read(item.port, banks.ov) & ~item.mask);
         end
         gppc_pkg::KIND_PORTIN, gppc_pkg::KIND_PININ: begin
            nxt.oe = gppc_pkg::lport_write(item.port, banks.oe,
                        gppc_pkg::lport_read(item.port, banks.oe) & ~m_eff);
            nxt.ge = gppc_pkg::lport_write(item.port, banks.ge,
                        gppc_pkg::lport_read(item.port, banks.ge) | m_eff);
         end
         gppc_pkg::KIND_PORTOUT, gppc_pkg::KIND_PINOUT: begin
            nxt.oe = gppc_pkg::lport_write(item.port, banks.oe,
                        gppc_pkg::lport_read(item.port, banks.oe) | m_eff);
            nxt.ge = gppc_pkg::lport_write(item.port, banks.ge,
                        gppc_pkg::lport_read(item.port, banks.ge) | m_eff);
         end
         gppc_pkg::KIND_GETVAL: begin
            // a zero mask selects the pin levels
            res = (item.mask == gppc_pkg::READ_IN_SENTINEL)
                ? gppc_pkg::lport_read(item.port, item.pins)
                : gppc_pkg::lport_read(item.port, banks.ov);
         end
         gppc_pkg::KIND_PINGET: begin
            res = {{(gppc_pkg::WORD_W-1){1'b0}},
                   |(gppc_pkg::lport_read(item.port, item.pins) & item.mask)};
         end
         gppc_pkg::KIND_PULLUP: begin
            nxt.pu = gppc_pkg::lport_write(item.port, banks.pu,
                        gppc_pkg::lport_read(item.port, banks.pu) | item.mask);
         end
         gppc_pkg::KIND_NOPULL: begin
            nxt.pu = gppc_pkg::lport_write(item.port, banks.pu,
                        gppc_pkg::lport_read(item.port, banks.pu) & ~item.mask);
         end
         default: begin
            res = gppc_pkg::RESULT_NONE;
         end
      endcase
   end

   assign upd.we  = item_valid && advance;
   assign upd.nxt = nxt;
   assign result  = res;

endmodule

>>> rtl/core/gppc_bank.sv
// gppc_bank: output value, gpio enable, output enable and pull-up registers
module gppc_bank (
   input  logic                   clock,
   input  logic                   reset,
   input  gppc_pkg::bank_upd_type upd,
   output gppc_pkg::banks_type    banks
);

   gppc_pkg::banks_type banks_ff, banks_in;

   always_comb begin
      banks_in = banks_ff;
      if (upd.we) begin
         banks_in = upd.nxt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         banks_ff <= '0;
      end else begin
         banks_ff <= banks_in;
      end
   end

   assign banks = banks_ff;

`ifndef SYNTHESIS
   a_reset_clears: assert property (@(posedge clock) reset |=> banks_ff == '0)
      else $error("bank not cleared by reset");
   a_hold_idle: assert property (@(posedge clock) disable iff (reset)
      !upd.we |=> $stable(banks_ff))
      else $error("bank changed without an update");
   a_port_a_top: assert property (@(posedge clock) disable iff (reset)
      $past(!reset) |-> !banks_ff.ov[0][gppc_pkg::WORD_W-1])
      else $error("output value bit 31 of port 0 set");
`endif

endmodule

>>> rtl/core/gppc_out_reg.sv
// gppc_out_reg: response register
module gppc_out_reg (
   input  logic               clock,
   input  logic               reset,
   gppc_rsp_if.source         rsp_chan,
   input  logic               load,
   input  gppc_pkg::word_type result,
   output logic               can_load
);

   logic               valid_ff, valid_in;
   gppc_pkg::word_type result_ff, result_in;

   assign can_load = !valid_ff || rsp_chan.ready;

   always_comb begin
      valid_in  = valid_ff;
      result_in = result_ff;
      if (can_load) begin
         valid_in  = load;
         result_in = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      result_ff <= result_in;
   end

   assign rsp_chan.valid  = valid_ff;
   assign rsp_chan.result = result_ff;

endmodule

>>> rtl/core/gpio_pseudo_port_controller_unit.sv
// a taken request goes from the input register to the response register
// throughput: one request per cycle while no response stalls, set by the single pass
// from input register to response register with the bank written back on the same edge
// reset: synchronous, clears all bank registers and both stage valid flags
// a stalled response holds the input stage, which then holds the request channel
module gpio_pseudo_port_controller_unit (
   input  logic       clock,
   input  logic       reset,
   gppc_req_if.sink   req_chan,
   gppc_rsp_if.source rsp_chan
);

   logic                   item_valid;
   logic                   can_load;
   gppc_pkg::req_item_type item;
   gppc_pkg::banks_type    banks;
   gppc_pkg::bank_upd_type upd;
   gppc_pkg::word_type     result;

   gppc_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .advance    (can_load),
      .item_valid (item_valid),
      .item       (item)
   );

   gppc_exec u_exec (
      .item_valid (item_valid),
      .advance    (can_load),
      .item       (item),
      .banks      (banks),
      .upd        (upd),
      .result     (result)
   );

   gppc_bank u_bank (
      .clock (clock),
      .reset (reset),
      .upd   (upd),
      .banks (banks)
   );

   gppc_out_reg u_out_reg (
      .clock    (clock),
      .reset    (reset),
      .rsp_chan (rsp_chan),
      .load     (item_valid),
      .result   (result),
      .can_load (can_load)
   );

`ifndef SYNTHESIS
   a_rsp_after_pass: assert property (@(posedge clock) disable iff (reset)
      (item_valid && can_load) |=> rsp_chan.valid)
      else $error("request passed without a response");
   a_req_to_stage: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> item_valid)
      else $error("accepted request not held");
   a_update_only_on_pass: assert property (@(posedge clock) disable iff (reset)
      upd.we |-> (item_valid && can_load))
      else $error("bank update without a request");
`endif

endmodule
